// File: rtl/core/csm_pkg.sv
// Shared types and constants for the int8 cosine similarity match block.
// Used by csm_ctrl, csm_dp and the top level; depends on nothing else.
`default_nettype none

package csm_pkg;

    localparam int MAX_LENGTH_DEF = 128;
    localparam int ELEM_W         = 8;
    localparam int DIFF_W         = ELEM_W + 1;
    localparam int SCORE_W        = 16;
    localparam int FRAC_BITS      = 15;
    localparam int SCORE_MAX      = 32767;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IN_OFFSET       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd1;

    localparam logic signed [ELEM_W-1:0]  IN_OFFSET_RESET  = 8'sd0;
    localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET  = 16'sd19661;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC_AB,
        S_MAC_AA,
        S_MAC_BB,
        S_PROD,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_csm_state;

    typedef enum logic [1:0] {
        MUL_AB,
        MUL_AA,
        MUL_BB,
        MUL_NN
    } t_csm_mul;

    typedef struct packed {
        logic     load_in;
        t_csm_mul mul_sel;
        logic     acc_en;
        logic     prod_en;
        logic     sqrt_step;
        logic     rem_clr;
        logic     div_step;
        logic     out_load;
    } t_csm_ctl;

    typedef struct packed {
        logic last;
        logic zero_norm;
        logic out_free;
    } t_csm_stat;

endpackage

`default_nettype wire

// File: rtl/core/int8_cosine_similarity_match.sv
// Top level of the int8 cosine similarity match block: configuration registers,
// sequencer and datapath. Depends on csm_pkg, csm_ctrl and csm_dp.
// An item without the last mark is accepted, then a*b, a*a and b*b are accumulated in turn.
// A last-marked item then forms the norm product and makes one root bit, then one quotient
// bit, per cycle; zero norms skip both. A result waits for a free output register. The score is
// offered from the next cycle. Synchronous active-low reset restores defaults and clears sums.
`default_nettype none

module int8_cosine_similarity_match
    import csm_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [ELEM_W-1:0]  i_elem_a,
    input  logic signed [ELEM_W-1:0]  i_elem_b,
    input  logic                      i_last_element,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [SCORE_W-1:0] o_score,
    output logic                      o_matched,
    output logic                      o_too_long,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    logic signed [ELEM_W-1:0]  r_in_offset;
    logic signed [SCORE_W-1:0] r_match_threshold;

    t_csm_ctl  ctl;
    t_csm_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_offset       <= IN_OFFSET_RESET;
            r_match_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IN_OFFSET:       r_in_offset       <= i_cfg_data[ELEM_W-1:0];
                REG_MATCH_THRESHOLD: r_match_threshold <= i_cfg_data[SCORE_W-1:0];
                default:             r_in_offset       <= r_in_offset;
            endcase
        end
    end

    csm_ctrl #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    csm_dp #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_in_offset       (r_in_offset),
        .i_match_threshold (r_match_threshold),
        .i_elem_a          (i_elem_a),
        .i_elem_b          (i_elem_b),
        .i_last_element    (i_last_element),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_score           (o_score),
        .o_matched         (o_matched),
        .o_too_long        (o_too_long)
    );

    // An accepted item keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // A result is loaded only when the output register is free.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a pending item");

    // A new result appears only from a load in the cycle before.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |=> o_out_valid)
        else $error("loaded result not offered");

    a_rise_needs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctl.out_load))
        else $error("output valid without a loaded result");

endmodule

`default_nettype wire

// File: rtl/core/csm_ctrl.sv
// Sequencer for the cosine similarity match block: state machine and iteration counter.
// Depends on csm_pkg; drives the control struct of csm_dp.
`default_nettype none

module csm_ctrl
    import csm_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_csm_stat i_stat,
    output t_csm_ctl  o_ctl
);

    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam int NORM_W = 16 + CNT_W;
    localparam int NUM_W  = NORM_W + FRAC_BITS;
    localparam int ITER_W = $clog2(NUM_W);

    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(NORM_W - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(NUM_W - 1);

    t_csm_state r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MAC_AB;
                end
            end
            S_MAC_AB: n_state = S_MAC_AA;
            S_MAC_AA: n_state = S_MAC_BB;
            S_MAC_BB: begin
                n_state = i_stat.last ? S_PROD : S_IDLE;
            end
            S_PROD: begin
                n_state = i_stat.zero_norm ? S_DONE : S_SQRT;
            end
            S_SQRT: begin
                if (r_iter == SQRT_LAST) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_iter == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_iter = '0;
        case (r_state)
            S_SQRT: n_iter = (r_iter == SQRT_LAST) ? '0 : r_iter + 1'b1;
            S_DIV:  n_iter = (r_iter == DIV_LAST) ? '0 : r_iter + 1'b1;
            default: n_iter = '0;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.mul_sel = MUL_AB;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_ctl.load_in = i_in_valid;
            end
            S_MAC_AB: begin
                o_ctl.mul_sel = MUL_AB;
                o_ctl.acc_en  = 1'b1;
            end
            S_MAC_AA: begin
                o_ctl.mul_sel = MUL_AA;
                o_ctl.acc_en  = 1'b1;
            end
            S_MAC_BB: begin
                o_ctl.mul_sel = MUL_BB;
                o_ctl.acc_en  = 1'b1;
            end
            S_PROD: begin
                o_ctl.mul_sel = MUL_NN;
                o_ctl.prod_en = 1'b1;
            end
            S_SQRT: begin
                o_ctl.sqrt_step = 1'b1;
                o_ctl.rem_clr   = (r_iter == SQRT_LAST);
            end
            S_DIV:  o_ctl.div_step  = 1'b1;
            S_DONE: o_ctl.out_load  = i_stat.out_free;
            default: o_ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/csm_dp.sv
// Datapath for the cosine similarity match block: accumulators, one shared multiplier,
// one shared subtractor for square root and division, and the output register. Uses csm_pkg.
`default_nettype none

module csm_dp
    import csm_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_csm_ctl                  i_ctl,
    output t_csm_stat                 o_stat,
    input  logic signed [ELEM_W-1:0]  i_in_offset,
    input  logic signed [SCORE_W-1:0] i_match_threshold,
    input  logic signed [ELEM_W-1:0]  i_elem_a,
    input  logic signed [ELEM_W-1:0]  i_elem_b,
    input  logic                      i_last_element,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [SCORE_W-1:0] o_score,
    output logic                      o_matched,
    output logic                      o_too_long
);

    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam int NORM_W = 16 + CNT_W;
    localparam int DOT_W  = NORM_W + 1;
    localparam int MUL_W  = NORM_W + 1;
    localparam int PROD_W = 2 * NORM_W;
    localparam int NUM_W  = NORM_W + FRAC_BITS;
    localparam int SUB_W  = NORM_W + 3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

    logic signed [DIFF_W-1:0] r_a, r_b;
    logic                     r_last, r_active;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_na, r_nb;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic [PROD_W-1:0]        r_prod;
    logic [NORM_W:0]          r_rem;
    logic [NORM_W-1:0]        r_root;
    logic [NUM_W-1:0]         r_num;
    logic                     r_neg, r_zero;
    logic                     r_out_valid;
    logic signed [SCORE_W-1:0] r_score;
    logic                     r_matched, r_too_long;

    logic signed [DIFF_W-1:0]  n_a, n_b;
    logic signed [MUL_W-1:0]   mul_x, mul_y;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [SUB_W-1:0]          sub_x, sub_y;
    logic [SUB_W:0]            sub_d;
    logic                      sub_ge;
    logic                      zero_c, out_free;
    logic signed [DOT_W-1:0]   dot_abs;
    logic [SCORE_W-1:0]        q_low;
    logic signed [SCORE_W-1:0] score_c;

    assign n_a = DIFF_W'(i_elem_a) - DIFF_W'(i_in_offset);
    assign n_b = DIFF_W'(i_elem_b) - DIFF_W'(i_in_offset);

    always_comb begin
        case (i_ctl.mul_sel)
            MUL_AB: begin
                mul_x = MUL_W'(r_a);
                mul_y = MUL_W'(r_b);
            end
            MUL_AA: begin
                mul_x = MUL_W'(r_a);
                mul_y = MUL_W'(r_a);
            end
            MUL_BB: begin
                mul_x = MUL_W'(r_b);
                mul_y = MUL_W'(r_b);
            end
            MUL_NN: begin
                mul_x = {1'b0, r_na};
                mul_y = {1'b0, r_nb};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb begin
        if (i_ctl.sqrt_step) begin
            sub_x = {r_rem, r_prod[PROD_W-1 -: 2]};
            sub_y = SUB_W'({r_root, 2'b01});
        end else begin
            sub_x = SUB_W'({r_rem[NORM_W-1:0], r_num[NUM_W-1]});
            sub_y = SUB_W'(r_root);
        end
    end

    assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
    assign sub_ge = !sub_d[SUB_W];

    assign zero_c   = (r_na == '0) || (r_nb == '0);
    assign out_free = !r_out_valid || !i_out_stall;
    assign dot_abs  = r_dot[DOT_W-1] ? -r_dot : r_dot;

    assign q_low = r_num[SCORE_W-1:0];

    always_comb begin
        if (r_zero) begin
            score_c = '0;
        end else if (r_neg) begin
            if (r_num > NUM_W'(SCORE_MAX + 1)) begin
                score_c = {1'b1, {(SCORE_W-1){1'b0}}};
            end else begin
                score_c = SCORE_W'(~q_low + SCORE_W'(1));
            end
        end else begin
            if (r_num > NUM_W'(SCORE_MAX)) begin
                score_c = {1'b0, {(SCORE_W-1){1'b1}}};
            end else begin
                score_c = q_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.out_load) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else if (i_ctl.load_in) begin
                if (r_cnt < MAX_CNT) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_ctl.acc_en && r_active) begin
                case (i_ctl.mul_sel)
                    MUL_AB:  r_dot <= r_dot + DOT_W'(mul_p);
                    MUL_AA:  r_na  <= r_na + mul_p[NORM_W-1:0];
                    MUL_BB:  r_nb  <= r_nb + mul_p[NORM_W-1:0];
                    default: r_dot <= r_dot;
                endcase
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The square root remainder is dropped after the last root bit so that the
    // division starts from an empty partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_last   <= i_last_element;
            r_active <= (r_cnt < MAX_CNT);
        end
        if (i_ctl.prod_en) begin
            r_prod <= mul_p[PROD_W-1:0];
            r_rem  <= '0;
            r_root <= '0;
            r_zero <= zero_c;
            r_neg  <= r_dot[DOT_W-1];
            r_num  <= {dot_abs[NORM_W-1:0], {FRAC_BITS{1'b0}}};
        end else if (i_ctl.sqrt_step) begin
            r_prod <= {r_prod[PROD_W-3:0], 2'b00};
            r_rem  <= i_ctl.rem_clr ? '0 : (sub_ge ? sub_d[NORM_W:0] : sub_x[NORM_W:0]);
            r_root <= {r_root[NORM_W-2:0], sub_ge};
        end else if (i_ctl.div_step) begin
            r_rem  <= {1'b0, sub_ge ? sub_d[NORM_W-1:0] : sub_x[NORM_W-1:0]};
            r_num  <= {r_num[NUM_W-2:0], sub_ge};
        end
        if (i_ctl.out_load) begin
            r_score    <= score_c;
            r_matched  <= (score_c >= i_match_threshold);
            r_too_long <= r_ovf;
        end
    end

    assign o_stat.last      = r_last;
    assign o_stat.zero_norm = zero_c;
    assign o_stat.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_matched   = r_matched;
    assign o_too_long  = r_too_long;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for int8_cosine_similarity_match: streams feature vectors under bursty input
// and a stalling output, and checks each score against a predictor built into the bench.
// Depends on csm_pkg and the RTL of the block only.

module testbench;
    import csm_pkg::*;

    localparam int MAX_LEN       = MAX_LENGTH_DEF;
    localparam int ITEM_TARGET   = 1450;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [ELEM_W-1:0]  t_elem;
    typedef logic signed [SCORE_W-1:0] t_score;

    typedef struct packed {
        t_score score;
        logic   matched;
        logic   too_long;
    } t_score_result;

    typedef enum int {
        VEC_RANDOM,
        VEC_SAME,
        VEC_OPPOSITE,
        VEC_NEAR,
        VEC_ZERO_A,
        VEC_ZERO_B,
        VEC_EXTREME
    } t_vec_kind;

    class t_score_tracker;
        t_elem         in_offset;
        t_score        threshold;
        longint        dot_acc;
        longint        norm_a_acc;
        longint        norm_b_acc;
        int            pair_count;
        bit            overflow;
        t_score_result pending[$];
        int            mismatches;
        int            scores_checked;
        int            zero_norms;
        int            saturations;
        int            too_longs;

        function new();
            in_offset      = IN_OFFSET_RESET;
            threshold      = THRESHOLD_RESET;
            mismatches     = 0;
            scores_checked = 0;
            zero_norms     = 0;
            saturations    = 0;
            too_longs      = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            dot_acc    = 0;
            norm_a_acc = 0;
            norm_b_acc = 0;
            pair_count = 0;
            overflow   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IN_OFFSET) begin
                in_offset = data[ELEM_W-1:0];
            end else if (idx == REG_MATCH_THRESHOLD) begin
                threshold = data;
            end
        endfunction

        function longint floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > n) probe >>= 2;
            while (probe != 0) begin
                if (n >= root + probe) begin
                    n    = n - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe >>= 2;
            end
            return longint'(root);
        endfunction

        function void note_pair(t_elem a, t_elem b, logic last);
            longint        da;
            longint        db;
            longint        quot;
            t_score_result res;
            da = longint'(a) - longint'(in_offset);
            db = longint'(b) - longint'(in_offset);
            if (pair_count < MAX_LEN) begin
                dot_acc    += da * db;
                norm_a_acc += da * da;
                norm_b_acc += db * db;
                pair_count++;
            end else begin
                overflow = 1'b1;
            end
            if (!last) return;
            if (norm_a_acc == 0 || norm_b_acc == 0) begin
                quot = 0;
                zero_norms++;
            end else begin
                quot = (dot_acc * 32768) / floor_root(norm_a_acc * norm_b_acc);
                if (quot > SCORE_MAX) begin
                    quot = SCORE_MAX;
                    saturations++;
                end else if (quot < -SCORE_MAX - 1) begin
                    quot = -SCORE_MAX - 1;
                    saturations++;
                end
            end
            res.score    = quot[SCORE_W-1:0];
            res.matched  = (quot >= longint'(threshold));
            res.too_long = overflow;
            if (overflow) too_longs++;
            pending.push_back(res);
            clear_sums();
        endfunction

        function void check_score(t_score s, logic m, logic t);
            t_score_result want;
            scores_checked++;
            if (pending.size() == 0) begin
                if (mismatches < 10) begin
                    $display("[%0t] unexpected score %0d matched %0b too_long %0b",
                             $realtime, s, m, t);
                end
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (want.score !== s || want.matched !== m || want.too_long !== t) begin
                if (mismatches < 10) begin
                    $display({"[%0t] score exp %0d got %0d, matched exp %0b got %0b, ",
                              "too_long exp %0b got %0b"},
                             $realtime, want.score, s, want.matched, m, want.too_long, t);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_elem                 elem_a = '0;
    t_elem                 elem_b = '0;
    logic                  last_el = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_score                score;
    logic                  matched;
    logic                  too_long;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_score_tracker tracker = new();

    int  items_sent = 0;
    int  burst_left = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  stall_run = 0;
    bit  stall_hold = 1'b0;
    int  cycles = 0;

    int8_cosine_similarity_match uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_elem_a       (elem_a),
        .i_elem_b       (elem_b),
        .i_last_element (last_el),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_score        (score),
        .o_matched      (matched),
        .o_too_long     (too_long),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("FAIL int8_cosine_similarity_match");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            tracker.check_score(score, matched, too_long);
        end
        if (stall_run == 0) begin
            stall_hold = ($urandom_range(0, 99) < stall_pct);
            stall_run  = $urandom_range(1, 12);
        end
        stall_run--;
        out_stall <= stall_hold;
    end

    function automatic t_elem clamp_elem(int v);
        if (v > 127) return 8'sd127;
        if (v < -128) return -8'sd128;
        return t_elem'(v);
    endfunction

    function automatic t_elem pick_extreme();
        case ($urandom_range(0, 3))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return -8'sd1;
            default: return 8'sd0;
        endcase
    endfunction

    task automatic send_pair(t_elem a, t_elem b, logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 99) < gap_pct) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        elem_a   <= a;
        elem_b   <= b;
        last_el  <= last;
        do @(posedge clk); while (in_stall);
        tracker.note_pair(a, b, last);
        items_sent++;
    endtask

    task automatic send_vector(int len, t_vec_kind kind);
        t_elem a;
        t_elem b;
        int    zp;
        int    noise;
        for (int i = 0; i < len; i++) begin
            zp    = tracker.in_offset;
            a     = t_elem'($urandom);
            b     = t_elem'($urandom);
            noise = $urandom_range(0, 6);
            case (kind)
                VEC_SAME:     b = a;
                VEC_OPPOSITE: b = clamp_elem(2 * zp - int'(a));
                VEC_NEAR:     b = clamp_elem(int'(a) + noise - 3);
                VEC_ZERO_A:   a = t_elem'(zp);
                VEC_ZERO_B:   b = t_elem'(zp);
                VEC_EXTREME: begin
                    a = pick_extreme();
                    b = pick_extreme();
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(t_elem zp, t_score thr, bit poke_unused);
        write_reg(REG_IN_OFFSET, {8'($urandom), zp});
        write_reg(REG_MATCH_THRESHOLD, thr);
        if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int        len;
        int        pick;
        t_vec_kind kind;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 30;
        stall_pct = 40;
        send_pair(8'sd127, 8'sd127, 1'b1);
        send_pair(-8'sd128, 8'sd127, 1'b1);
        send_pair(-8'sd128, -8'sd128, 1'b1);
        send_pair(8'sd127, -8'sd128, 1'b1);
        send_pair(8'sd0, 8'sd77, 1'b1);
        send_pair(-8'sd5, 8'sd0, 1'b0);
        send_pair(8'sd3, 8'sd0, 1'b1);
        send_pair(8'sd0, 8'sd0, 1'b1);
        send_pair(8'sd100, -8'sd100, 1'b0);
        send_pair(-8'sd100, 8'sd100, 1'b0);
        send_pair(8'sd50, -8'sd50, 1'b1);
        send_pair(8'sd3, 8'sd5, 1'b0);
        send_pair(8'sd4, 8'sd0, 1'b1);
        send_pair(8'sd4, 8'sd5, 1'b0);
        send_pair(8'sd3, 8'sd0, 1'b1);
        send_pair(8'sd10, 8'sd20, 1'b0);
        send_pair(-8'sd30, 8'sd7, 1'b0);
        send_pair(8'sd1, -8'sd1, 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                in_valid <= 1'b0;
                wait_idle();
                case (phase)
                    1: configure(-8'sd128, -16'sd32768, 1'b1);
                    2: configure(8'sd127, 16'sd32767, 1'b0);
                    3: configure(8'sd0, 16'sd0, 1'b1);
                    default: configure(t_elem'($urandom), t_score'($urandom), phase[0]);
                endcase
            end
            if (phase % 3 == 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 60);
                stall_pct = $urandom_range(10, 70);
            end
            if (phase == 1) send_vector(MAX_LEN + 3, VEC_RANDOM);
            while (items_sent < ITEM_TARGET * (phase + 1) / NUM_PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) len = $urandom_range(1, 8);
                else if (pick < 90) len = $urandom_range(9, 40);
                else if (pick < 96) len = $urandom_range(41, MAX_LEN);
                else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
                kind = t_vec_kind'($urandom_range(0, 6));
                send_vector(len, kind);
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        $display("Sent %0d element pairs over %0d register settings; %0d scores checked.",
                 items_sent, NUM_PHASES, tracker.scores_checked);
        $display("Zero-norm vectors %0d, saturated scores %0d, over-length vectors %0d.",
                 tracker.zero_norms, tracker.saturations, tracker.too_longs);
        if (tracker.mismatches == 0) begin
            $display("PASS int8_cosine_similarity_match");
        end else begin
            $display("%0d mismatches.", tracker.mismatches);
            $display("FAIL int8_cosine_similarity_match");
        end
        $finish;
    end

endmodule
